// File: rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, types and helpers for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int DIST_WIDTH = 25;

  // coordinate difference, signed product, squared length (unsigned)
  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * DW;
  localparam int L2W  = PW - 1;
  // |cross| magnitude and its split for partial products
  localparam int CW   = L2W;
  localparam int LOW  = (CW + 1) / 2;
  localparam int HIW  = CW - LOW;
  // dividend, quotient (radicand), root
  localparam int NUMW = 2 * CW + 2 * FRAC_BITS;
  localparam int QW   = L2W + 2 * FRAC_BITS;
  localparam int RW   = (QW + 1) / 2;
  localparam int SQW  = 2 * RW;
  localparam int XW   = (RW > DIST_WIDTH) ? RW : DIST_WIDTH;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [DIST_WIDTH-1:0]        dist_t;

  typedef enum logic [1:0] {
    KIND_DEGEN    = 2'd0,
    KIND_BEFORE   = 2'd1,
    KIND_BEYOND   = 2'd2,
    KIND_INTERIOR = 2'd3
  } kind_t;

  typedef struct packed {
    logic  vld;
    kind_t kind;
  } psd_tag_t;

  // clamp the root to the result field
  function automatic dist_t dist_of(input logic [RW-1:0] root);
    logic [XW-1:0] r;
    r = XW'(root);
    if (r > XW'({DIST_WIDTH{1'b1}})) begin
      return {DIST_WIDTH{1'b1}};
    end
    return r[DIST_WIDTH-1:0];
  endfunction

endpackage

// File: rtl/core/psd_in_if.sv
// ----------------------------------------------------------------------------
// psd_in_if
// Query channel: segment endpoints and query point, valid/ready.
// ----------------------------------------------------------------------------
interface psd_in_if;
  import psd_pkg::*;

  logic   valid;
  logic   ready;
  coord_t seg_start_x;
  coord_t seg_start_y;
  coord_t seg_end_x;
  coord_t seg_end_y;
  coord_t point_x;
  coord_t point_y;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y, point_x, point_y,
    output ready
  );
endinterface

// File: rtl/core/psd_out_if.sv
// ----------------------------------------------------------------------------
// psd_out_if
// Result channel: distance and nearest case, valid/ready.
// ----------------------------------------------------------------------------
interface psd_out_if;
  import psd_pkg::*;

  logic  valid;
  logic  ready;
  dist_t distance;
  kind_t nearest_kind;

  modport source (output valid, distance, nearest_kind, input ready);
  modport sink   (input valid, distance, nearest_kind, output ready);
endinterface

// File: rtl/core/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Six stages: differences, products, sums, case select, |cross|^2 partial
// products, dividend/divisor forming.
// ----------------------------------------------------------------------------
module psd_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  psd_pkg::coord_t           sx,
  input  psd_pkg::coord_t           sy,
  input  psd_pkg::coord_t           ex,
  input  psd_pkg::coord_t           ey,
  input  psd_pkg::coord_t           px,
  input  psd_pkg::coord_t           py,
  output psd_pkg::psd_tag_t         o_tag,
  output logic [psd_pkg::NUMW-1:0]  o_num,
  output logic [psd_pkg::L2W-1:0]   o_den
);
  import psd_pkg::*;

  logic [5:0] vld_r;

  // stage 1
  logic signed [DW-1:0] ux_r, uy_r, vx_r, vy_r, wx_r, wy_r;
  // stage 2
  logic signed [PW-1:0] p_uu_r, p_yy_r, p_vxux_r, p_vyuy_r, p_vxvx_r, p_vyvy_r;
  logic signed [PW-1:0] p_wxwx_r, p_wywy_r, p_uxvy_r, p_uyvx_r;
  // stage 3
  logic [L2W-1:0]       l2_r, lv_r, lw_r;
  logic signed [PW-1:0] dot_r, cr_r;
  logic [PW-1:0]        l2_nxt, lv_nxt, lw_nxt;
  logic [PW:0]          dot_nxt, cr_nxt;
  // stage 4
  kind_t                kind4_r;
  logic [L2W-1:0]       len4_r, l2_4_r;
  logic [CW-1:0]        acr_r;
  kind_t                kind_nxt;
  logic [PW-1:0]        acr_nxt;
  // stage 5
  kind_t                kind5_r;
  logic [L2W-1:0]       len5_r, l2_5_r;
  logic [2*LOW-1:0]     pll_r;
  logic [LOW+HIW-1:0]   plh_r;
  logic [2*HIW-1:0]     phh_r;
  // stage 6
  kind_t                kind6_r;
  logic [NUMW-1:0]      num_r;
  logic [L2W-1:0]       den_r;
  logic [2*CW-1:0]      crsq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  assign l2_nxt  = PW'($unsigned(p_uu_r)) + PW'($unsigned(p_yy_r));
  assign lv_nxt  = PW'($unsigned(p_vxvx_r)) + PW'($unsigned(p_vyvy_r));
  assign lw_nxt  = PW'($unsigned(p_wxwx_r)) + PW'($unsigned(p_wywy_r));
  assign dot_nxt = {p_vxux_r[PW-1], p_vxux_r} + {p_vyuy_r[PW-1], p_vyuy_r};
  assign cr_nxt  = {p_uxvy_r[PW-1], p_uxvy_r} - {p_uyvx_r[PW-1], p_uyvx_r};

  always_comb begin
    if (l2_r == '0) begin
      kind_nxt = KIND_DEGEN;
    end else if (dot_r[PW-1]) begin
      kind_nxt = KIND_BEFORE;
    end else if (dot_r[PW-2:0] > l2_r) begin
      kind_nxt = KIND_BEYOND;
    end else begin
      kind_nxt = KIND_INTERIOR;
    end
  end

  assign acr_nxt  = cr_r[PW-1] ? (PW'(0) - PW'($unsigned(cr_r))) : PW'($unsigned(cr_r));
  assign crsq_nxt = ((2*CW)'(phh_r) << (2*LOW)) + ((2*CW)'(plh_r) << (LOW+1))
                  + (2*CW)'(pll_r);

  always_ff @(posedge clk) begin
    if (en) begin
      ux_r <= {ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx};
      uy_r <= {ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy};
      vx_r <= {px[COORD_BITS-1], px} - {sx[COORD_BITS-1], sx};
      vy_r <= {py[COORD_BITS-1], py} - {sy[COORD_BITS-1], sy};
      wx_r <= {px[COORD_BITS-1], px} - {ex[COORD_BITS-1], ex};
      wy_r <= {py[COORD_BITS-1], py} - {ey[COORD_BITS-1], ey};

      p_uu_r   <= ux_r * ux_r;
      p_yy_r   <= uy_r * uy_r;
      p_vxux_r <= vx_r * ux_r;
      p_vyuy_r <= vy_r * uy_r;
      p_vxvx_r <= vx_r * vx_r;
      p_vyvy_r <= vy_r * vy_r;
      p_wxwx_r <= wx_r * wx_r;
      p_wywy_r <= wy_r * wy_r;
      p_uxvy_r <= ux_r * vy_r;
      p_uyvx_r <= uy_r * vx_r;

      l2_r  <= l2_nxt[L2W-1:0];
      lv_r  <= lv_nxt[L2W-1:0];
      lw_r  <= lw_nxt[L2W-1:0];
      dot_r <= dot_nxt[PW-1:0];
      cr_r  <= cr_nxt[PW-1:0];

      kind4_r <= kind_nxt;
      len4_r  <= (kind_nxt == KIND_BEYOND) ? lw_r : lv_r;
      l2_4_r  <= l2_r;
      acr_r   <= acr_nxt[CW-1:0];

      kind5_r <= kind4_r;
      len5_r  <= len4_r;
      l2_5_r  <= l2_4_r;
      pll_r   <= (2*LOW)'(acr_r[LOW-1:0]) * (2*LOW)'(acr_r[LOW-1:0]);
      plh_r   <= (LOW+HIW)'(acr_r[LOW-1:0]) * (LOW+HIW)'(acr_r[CW-1:LOW]);
      phh_r   <= (2*HIW)'(acr_r[CW-1:LOW]) * (2*HIW)'(acr_r[CW-1:LOW]);

      kind6_r <= kind5_r;
      if (kind5_r == KIND_INTERIOR) begin
        num_r <= NUMW'(crsq_nxt) << (2*FRAC_BITS);
        den_r <= l2_5_r;
      end else begin
        num_r <= NUMW'(len5_r) << (2*FRAC_BITS);
        den_r <= L2W'(1);
      end
    end
  end

  assign o_tag = '{vld: vld_r[5], kind: kind6_r};
  assign o_num = num_r;
  assign o_den = den_r;

endmodule

// File: rtl/core/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module psd_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  psd_pkg::psd_tag_t         i_tag,
  input  logic [psd_pkg::NUMW-1:0]  i_num,
  input  logic [psd_pkg::L2W-1:0]   i_den,
  output psd_pkg::psd_tag_t         o_tag,
  output logic [psd_pkg::QW-1:0]    o_quo
);
  import psd_pkg::*;

  logic           vld_r  [QW];
  kind_t          kind_r [QW];
  logic [L2W-1:0] rem_r  [QW];
  logic [L2W-1:0] den_r  [QW];
  logic [QW-1:0]  sh_r   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stg
    logic           vld_i;
    kind_t          kind_i;
    logic [L2W-1:0] rem_i, den_i;
    logic [QW-1:0]  sh_i;
    logic [L2W:0]   t;
    logic [L2W:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_i  = i_tag.vld;
      assign kind_i = i_tag.kind;
      assign rem_i  = i_num[NUMW-1:QW];
      assign sh_i   = i_num[QW-1:0];
      assign den_i  = i_den;
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign kind_i = kind_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign sh_i   = sh_r[k-1];
      assign den_i  = den_r[k-1];
    end

    assign t    = {rem_i, sh_i[QW-1]};
    assign diff = t - {1'b0, den_i};
    assign ge   = (t >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        kind_r[k] <= kind_i;
        rem_r[k]  <= ge ? diff[L2W-1:0] : t[L2W-1:0];
        sh_r[k]   <= {sh_i[QW-2:0], ge};
        den_r[k]  <= den_i;
      end
    end
  end

  assign o_tag = '{vld: vld_r[QW-1], kind: kind_r[QW-1]};
  assign o_quo = sh_r[QW-1];

endmodule

// File: rtl/core/psd_sqrt.sv
// ----------------------------------------------------------------------------
// psd_sqrt
// Digit-by-digit integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module psd_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  psd_pkg::psd_tag_t       i_tag,
  input  logic [psd_pkg::QW-1:0]  i_rad,
  output psd_pkg::psd_tag_t       o_tag,
  output logic [psd_pkg::RW-1:0]  o_root
);
  import psd_pkg::*;

  logic          vld_r  [RW];
  kind_t         kind_r [RW];
  logic [RW:0]   rem_r  [RW];
  logic [RW-1:0] root_r [RW];
  logic [SQW-1:0] sh_r  [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stg
    logic           vld_i;
    kind_t          kind_i;
    logic [RW:0]    rem_i;
    logic [RW-1:0]  root_i;
    logic [SQW-1:0] sh_i;
    logic [RW+2:0]  t, trial, diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_i  = i_tag.vld;
      assign kind_i = i_tag.kind;
      assign rem_i  = '0;
      assign root_i = '0;
      assign sh_i   = SQW'(i_rad);
    end else begin : g_next
      assign vld_i  = vld_r[k-1];
      assign kind_i = kind_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign sh_i   = sh_r[k-1];
    end

    assign t     = {rem_i, sh_i[SQW-1:SQW-2]};
    assign trial = {1'b0, root_i, 2'b01};
    assign diff  = t - trial;
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        kind_r[k] <= kind_i;
        rem_r[k]  <= ge ? diff[RW:0] : t[RW:0];
        root_r[k] <= {root_i[RW-2:0], ge};
        sh_r[k]   <= sh_i << 2;
      end
    end
  end

  assign o_tag  = '{vld: vld_r[RW-1], kind: kind_r[RW-1]};
  assign o_root = root_r[RW-1];

endmodule

// File: rtl/core/point_segment_distance.sv
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a query point to a line segment, fully pipelined.
//
// in_ch carries one query per beat: segment start, segment end and the query
// point as signed coordinates. out_ch returns one beat per query, in order:
// the distance in unsigned fixed point (8 fraction bits, truncated) and the
// case that applied (degenerate, before start, beyond end, interior).
// From the input beat to the output beat a query passes through 6 front stages
// (differences, products, sums, case select, |cross|^2, operand forming),
// 49 divider stages (one quotient bit each) and 25 root stages (one root bit
// each). The last root stage is the output register.
// Throughput is one query per cycle while out_ch is not stalled; the pipeline
// holds up to 80 queries. When out_ch stalls the whole pipeline holds and
// in_ch.ready drops; nothing is lost or repeated. A synchronous reset clears
// all valid bits, so the pipeline comes up empty; there are no tables to clear.
// ----------------------------------------------------------------------------
module point_segment_distance (
  input  logic        clk,
  input  logic        rst_n,
  psd_in_if.sink      in_ch,
  psd_out_if.source   out_ch
);
  import psd_pkg::*;

  logic            en;
  psd_tag_t        f_tag, d_tag, s_tag;
  logic [NUMW-1:0] f_num;
  logic [L2W-1:0]  f_den;
  logic [QW-1:0]   d_quo;
  logic [RW-1:0]   s_root;

  assign en          = !s_tag.vld || out_ch.ready;
  assign in_ch.ready = en;

  psd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_ch.valid),
    .sx     (in_ch.seg_start_x),
    .sy     (in_ch.seg_start_y),
    .ex     (in_ch.seg_end_x),
    .ey     (in_ch.seg_end_y),
    .px     (in_ch.point_x),
    .py     (in_ch.point_y),
    .o_tag  (f_tag),
    .o_num  (f_num),
    .o_den  (f_den)
  );

  psd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .i_tag (f_tag),
    .i_num (f_num),
    .i_den (f_den),
    .o_tag (d_tag),
    .o_quo (d_quo)
  );

  psd_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .i_tag  (d_tag),
    .i_rad  (d_quo),
    .o_tag  (s_tag),
    .o_root (s_root)
  );

  assign out_ch.valid        = s_tag.vld;
  assign out_ch.distance     = dist_of(s_root);
  assign out_ch.nearest_kind = s_tag.kind;

endmodule

// File: rtl/core/psd_checker.sv
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks for point_segment_distance, bound to the top level.
// ----------------------------------------------------------------------------
module psd_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input psd_pkg::dist_t    out_distance,
  input psd_pkg::kind_t    out_kind
);
  import psd_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_kind))
    else $error("result beat changed under stall");

  // input side is held only by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in ready does not follow output stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a fresh result needs a beat taken earlier
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(!rst_n))
    else $error("result appeared right out of reset");

endmodule

bind point_segment_distance psd_checker u_psd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_distance (out_ch.distance),
  .out_kind     (out_ch.nearest_kind)
);
